@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the text rectangle generator.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FTRG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FTRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ftrg_pkg.sv @@
// Package for the font text rectangle generator: payload structs, opcodes,
// font constants and the 5x7 glyph table. No dependencies.
`default_nettype none

package ftrg_pkg;

   localparam int GLYPH_COUNT = 39;

   localparam logic [1:0] OP_START_X      = 2'd0;
   localparam logic [1:0] OP_START_CENTER = 2'd1;
   localparam logic [1:0] OP_CHAR         = 2'd2;

   localparam int FONT_COLS = 5;
   localparam int FONT_ROWS = 7;
   localparam int DOT_COUNT = FONT_COLS * FONT_ROWS;

   localparam logic [11:0]        FB_LIMIT   = 12'd2048;
   localparam logic signed [16:0] CURSOR_MAX = 17'sd32767;

   typedef struct packed {
      logic [1:0]        opcode;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [7:0]        text_length;
      logic [15:0]       ink_colour;
      logic [3:0]        pixel_scale;
      logic [7:0]        char_code;
   } req_type;

   typedef struct packed {
      logic [10:0] rect_x;
      logic [10:0] rect_y;
      logic [3:0]  rect_w;
      logic [3:0]  rect_h;
      logic [15:0] rect_colour;
      logic        last_rect;
   } rsp_type;

   function automatic logic [5:0] glyph_index(input logic [7:0] code);
      logic [7:0] c;
      logic [5:0] idx;
      c   = code;
      idx = 6'd0;
      if (c >= 8'h61 && c <= 8'h7A) begin
         c = c - 8'd32;
      end
      if (c >= 8'h41 && c <= 8'h5A) begin
         idx = 6'(c - 8'h41) + 6'd1;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         idx = 6'(c - 8'h30) + 6'd27;
      end else if (c == 8'h2E) begin
         idx = 6'd37;
      end else if (c == 8'h2D) begin
         idx = 6'd38;
      end
      if (int'(idx) >= GLYPH_COUNT) begin
         idx = 6'd0;
      end
      return idx;
   endfunction

   // Column bytes, column 0 in the top byte; bit r of a column is row r.
   function automatic logic [39:0] glyph_cols(input logic [5:0] idx);
      logic [39:0] g;
      case (idx)
         6'd1:    g = 40'h7C_12_11_12_7C;
         6'd2:    g = 40'h7F_49_49_49_36;
         6'd3:    g = 40'h3E_41_41_41_22;
         6'd4:    g = 40'h7F_41_41_22_1C;
         6'd5:    g = 40'h7F_49_49_49_41;
         6'd6:    g = 40'h7F_09_09_09_01;
         6'd7:    g = 40'h3E_41_41_51_72;
         6'd8:    g = 40'h7F_08_08_08_7F;
         6'd9:    g = 40'h00_41_7F_41_00;
         6'd10:   g = 40'h20_40_41_3F_01;
         6'd11:   g = 40'h7F_08_14_22_41;
         6'd12:   g = 40'h7F_40_40_40_40;
         6'd13:   g = 40'h7F_02_0C_02_7F;
         6'd14:   g = 40'h7F_04_08_10_7F;
         6'd15:   g = 40'h3E_41_41_41_3E;
         6'd16:   g = 40'h7F_09_09_09_06;
         6'd17:   g = 40'h3E_41_51_21_5E;
         6'd18:   g = 40'h7F_09_19_29_46;
         6'd19:   g = 40'h46_49_49_49_31;
         6'd20:   g = 40'h01_01_7F_01_01;
         6'd21:   g = 40'h3F_40_40_40_3F;
         6'd22:   g = 40'h1F_20_40_20_1F;
         6'd23:   g = 40'h3F_40_38_40_3F;
         6'd24:   g = 40'h63_14_08_14_63;
         6'd25:   g = 40'h07_08_70_08_07;
         6'd26:   g = 40'h61_51_49_45_43;
         6'd27:   g = 40'h3E_51_49_45_3E;
         6'd28:   g = 40'h00_42_7F_40_00;
         6'd29:   g = 40'h42_61_51_49_46;
         6'd30:   g = 40'h21_41_45_4B_31;
         6'd31:   g = 40'h18_14_12_7F_10;
         6'd32:   g = 40'h27_45_45_45_39;
         6'd33:   g = 40'h3C_4A_49_49_30;
         6'd34:   g = 40'h01_71_09_05_03;
         6'd35:   g = 40'h36_49_49_49_36;
         6'd36:   g = 40'h06_49_49_29_1E;
         6'd37:   g = 40'h00_00_60_60_00;
         6'd38:   g = 40'h00_00_5F_00_00;
         default: g = 40'h00_00_00_00_00;
      endcase
      return g;
   endfunction

   // Dot bits in scan order: bit col*FONT_ROWS+row.
   function automatic logic [DOT_COUNT-1:0] glyph_dots(input logic [7:0] code);
      logic [39:0]          cols;
      logic [DOT_COUNT-1:0] dots;
      cols = glyph_cols(glyph_index(code));
      for (int k = 0; k < FONT_COLS; k++) begin
         dots[k*FONT_ROWS +: FONT_ROWS] = cols[38 - 8*k -: FONT_ROWS];
      end
      return dots;
   endfunction

endpackage

`default_nettype wire

@@ rtl/font_text_rect_generator.sv @@
// Top level of the 5x7 font text rectangle generator: configuration registers,
// dot scan sequencer, shared clip unit and result register. Uses ftrg_pkg.
`default_nettype none

// A start transaction (opcode 0 or 1) sets the line origin, ink colour and dot
// scale and produces no result; a centred start registers its width product
// before the subtraction. In a character transaction (opcode 2) a sequencer
// walks the 35 font dots column by column, one dot per cycle unless the result
// channel holds the scan back, through a single shared clip unit, and a one-entry
// hold stage lets the last visible rectangle be flagged before it leaves.
// req_ready is low while a character is being scanned. Opcode 3 is accepted
// and ignored. fb_width and fb_height (byte addresses 0 and 4) reset to 480 and
// 320; values above 2048 act as 2048 when clipping, while a centred start uses
// the width as written. There is no clearing pass after reset.
module font_text_rect_generator
   import ftrg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire req_type     req_payload,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      rsp_type     rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CENTER = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FLUSH  = 2'd3;

   localparam logic REG_FB_WIDTH  = 1'b0;
   localparam logic REG_FB_HEIGHT = 1'b1;

   localparam logic [5:0] LAST_DOT = 6'(DOT_COUNT - 1);
   localparam logic [2:0] LAST_ROW = 3'(FONT_ROWS - 1);

   logic [11:0] fb_width_ff, fb_height_ff;
   logic [1:0]  state_ff, state_in;

   logic signed [15:0] cursor_ff, cursor_in;
   logic signed [11:0] line_y_ff, line_y_in;
   logic [15:0]        colour_ff, colour_in;
   logic [3:0]         scale_ff, scale_in;
   logic [14:0]        tw_ff, tw_in;

   logic [DOT_COUNT-1:0] glyph_ff, glyph_in;
   logic [5:0]           dot_cnt_ff, dot_cnt_in;
   logic [2:0]           row_ff, row_in;
   logic signed [16:0]   xpos_ff, xpos_in;
   logic signed [12:0]   ypos_ff, ypos_in;

   logic    hold_valid_ff, hold_valid_in;
   rsp_type hold_ff, hold_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic        cfg_write;
   logic        req_fire;
   logic        slot_free;
   logic        push;
   rsp_type     push_data;
   logic [11:0] wl, hl;
   logic [6:0]  six_req, six_line;

   logic signed [17:0] x_lo, x_hi, x_lim, x_end, x_span;
   logic signed [13:0] y_lo, y_hi, y_lim, y_end, y_span;
   logic               dot_vis;
   rsp_type            dot_rect;

   logic signed [15:0] center_diff;
   logic signed [16:0] cursor_sum;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_FB_HEIGHT) ? {20'd0, fb_height_ff}
                                                       : {20'd0, fb_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= 12'd480;
         fb_height_ff <= 12'd320;
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_FB_WIDTH) begin
            fb_width_ff <= csr_pwdata[11:0];
         end else begin
            fb_height_ff <= csr_pwdata[11:0];
         end
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   assign wl       = (fb_width_ff > FB_LIMIT) ? FB_LIMIT : fb_width_ff;
   assign hl       = (fb_height_ff > FB_LIMIT) ? FB_LIMIT : fb_height_ff;
   assign six_req  = 7'({req_payload.pixel_scale, 1'b0}) + 7'({req_payload.pixel_scale, 2'b0});
   assign six_line = 7'({scale_ff, 1'b0}) + 7'({scale_ff, 2'b0});

   // Shared clip unit: clips the current dot square against the framebuffer.
   always_comb begin
      x_lo   = xpos_ff[16] ? 18'sd0 : $signed({1'b0, xpos_ff});
      x_hi   = $signed({xpos_ff[16], xpos_ff}) + $signed({14'd0, scale_ff});
      x_lim  = $signed({6'd0, wl});
      x_end  = (x_hi < x_lim) ? x_hi : x_lim;
      x_span = x_end - x_lo;
      y_lo   = ypos_ff[12] ? 14'sd0 : $signed({1'b0, ypos_ff});
      y_hi   = $signed({ypos_ff[12], ypos_ff}) + $signed({10'd0, scale_ff});
      y_lim  = $signed({2'd0, hl});
      y_end  = (y_hi < y_lim) ? y_hi : y_lim;
      y_span = y_end - y_lo;
      dot_vis = glyph_ff[0] && (x_end > x_lo) && (y_end > y_lo);
      dot_rect.rect_x      = x_lo[10:0];
      dot_rect.rect_y      = y_lo[10:0];
      dot_rect.rect_w      = x_span[3:0];
      dot_rect.rect_h      = y_span[3:0];
      dot_rect.rect_colour = colour_ff;
      dot_rect.last_rect   = 1'b0;
   end

   assign center_diff = $signed({4'd0, fb_width_ff}) - $signed({1'b0, tw_ff});
   assign cursor_sum  = $signed({cursor_ff[15], cursor_ff}) + $signed({10'd0, six_line});

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      line_y_in     = line_y_ff;
      colour_in     = colour_ff;
      scale_in      = scale_ff;
      tw_in         = tw_ff;
      glyph_in      = glyph_ff;
      dot_cnt_in    = dot_cnt_ff;
      row_in        = row_ff;
      xpos_in       = xpos_ff;
      ypos_in       = ypos_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      push          = 1'b0;
      push_data     = hold_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.opcode == OP_START_X || req_payload.opcode == OP_START_CENTER) begin
                  line_y_in = req_payload.pos_y;
                  colour_in = req_payload.ink_colour;
                  scale_in  = req_payload.pixel_scale;
                  if (req_payload.opcode == OP_START_X) begin
                     cursor_in = 16'(req_payload.pos_x);
                  end else begin
                     tw_in    = 15'(req_payload.text_length) * 15'(six_req);
                     state_in = ST_CENTER;
                  end
               end else if (req_payload.opcode == OP_CHAR) begin
                  glyph_in   = glyph_dots(req_payload.char_code);
                  dot_cnt_in = 6'd0;
                  row_in     = 3'd0;
                  xpos_in    = 17'(cursor_ff);
                  ypos_in    = 13'(line_y_ff);
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_CENTER: begin
            cursor_in = (center_diff > 16'sd0) ? {1'b0, center_diff[15:1]} : 16'sd0;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            if (!(dot_vis && hold_valid_ff && !slot_free)) begin
               if (dot_vis) begin
                  push          = hold_valid_ff;
                  hold_in       = dot_rect;
                  hold_valid_in = 1'b1;
               end
               glyph_in   = glyph_ff >> 1;
               dot_cnt_in = dot_cnt_ff + 6'd1;
               if (row_ff == LAST_ROW) begin
                  row_in  = 3'd0;
                  ypos_in = 13'(line_y_ff);
                  xpos_in = xpos_ff + $signed({13'd0, scale_ff});
               end else begin
                  row_in  = row_ff + 3'd1;
                  ypos_in = ypos_ff + $signed({9'd0, scale_ff});
               end
               if (dot_cnt_ff == LAST_DOT) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff || slot_free) begin
               push                = hold_valid_ff;
               push_data.last_rect = 1'b1;
               hold_valid_in       = 1'b0;
               cursor_in = (cursor_sum > CURSOR_MAX) ? CURSOR_MAX[15:0] : cursor_sum[15:0];
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_ff     <= '0;
         line_y_ff     <= '0;
         colour_ff     <= '0;
         scale_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         line_y_ff     <= line_y_in;
         colour_ff     <= colour_in;
         scale_ff      <= scale_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tw_ff      <= tw_in;
      glyph_ff   <= glyph_in;
      dot_cnt_ff <= dot_cnt_in;
      row_ff     <= row_in;
      xpos_ff    <= xpos_in;
      ypos_ff    <= ypos_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

@@ rtl/ftrg_checker.sv @@
// Port-level checker for the font text rectangle generator, bound to the top
// level. Uses ftrg_pkg and the macros in assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ftrg_checker
   import ftrg_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire req_type     req_payload,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_payload,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pready
);

   `FTRG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result transaction changed")
   `FTRG_ASSERT_IMPL(a_rect_size, clock, reset, rsp_valid, rsp_payload.rect_w != 4'd0 && rsp_payload.rect_h != 4'd0, "empty rectangle emitted")
   `FTRG_ASSERT_IMPL(a_rect_inside, clock, reset, rsp_valid, ({1'b0, rsp_payload.rect_x} + 12'(rsp_payload.rect_w)) <= 12'd2048 && ({1'b0, rsp_payload.rect_y} + 12'(rsp_payload.rect_h)) <= 12'd2048, "rectangle beyond framebuffer limit")
   `FTRG_ASSERT_NEXT(a_char_busy, clock, reset, req_valid && req_ready && req_payload.opcode == OP_CHAR, !req_ready, "ready while a character is scanned")
   `FTRG_ASSERT_IMPL(a_pready, clock, reset, csr_psel && csr_penable, csr_pready, "configuration access stalled")

endmodule

bind font_text_rect_generator ftrg_checker u_ftrg_checker (.*);

`default_nettype wire

@@ tb/ftrg_rect_check.sv @@
// Register map constants and the rectangle checker of the font text rectangle generator.
// The checker watches both channels and the register port, predicts each dot rectangle
// and compares it field by field. Depends on ftrg_pkg.
`default_nettype none

package ftrg_csr_map_pkg;
   localparam logic [2:0] CSR_FB_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FB_HEIGHT = 3'd4;
endpackage

module ftrg_rect_check
   import ftrg_pkg::*;
   import ftrg_csr_map_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_payload,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               rects_in_flight,
   output int               rects_seen,
   output int               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FONT_ENTRIES = 39;
   localparam int MAX_PRINTED  = 40;

   localparam logic [0:FONT_ENTRIES-1][39:0] GLYPH_BITMAPS = {
      40'h00_00_00_00_00,
      40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22, 40'h7F_41_41_22_1C,
      40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_41_51_72, 40'h7F_08_08_08_7F,
      40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
      40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E, 40'h7F_09_09_09_06,
      40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7F_01_01,
      40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
      40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h3E_51_49_45_3E, 40'h00_42_7F_40_00,
      40'h42_61_51_49_46, 40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
      40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36, 40'h06_49_49_29_1E,
      40'h00_00_60_60_00, 40'h00_00_5F_00_00
   };

   logic [11:0]        fb_width  = 12'd480;
   logic [11:0]        fb_height = 12'd320;
   logic signed [15:0] pen_x     = '0;
   logic signed [11:0] line_y    = '0;
   logic [15:0]        line_colour = '0;
   logic [3:0]         line_scale  = '0;
   rsp_type            dot_rects[$];
   int                 mismatches = 0;
   int                 checked    = 0;

   function automatic int font_slot(input logic [7:0] code);
      int c;
      int slot;
      c    = code;
      slot = 0;
      if (c >= "a" && c <= "z") begin
         c = c - "a" + "A";
      end
      if (c >= "A" && c <= "Z") begin
         slot = 1 + c - "A";
      end else if (c >= "0" && c <= "9") begin
         slot = 27 + c - "0";
      end else if (c == ".") begin
         slot = 37;
      end else if (c == "-") begin
         slot = 38;
      end
      if (slot >= GLYPH_COUNT || slot >= FONT_ENTRIES) begin
         slot = 0;
      end
      return slot;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("[%0t] rectangle %0d: %s", $time, checked, what);
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] seen,
                              input logic [15:0] want);
      if (seen !== want) begin
         report_mismatch($sformatf("%s is %0h, predicted %0h", field, seen, want));
      end
   endtask

   task automatic draw_char(input logic [7:0] code);
      logic [39:0] cols;
      logic [7:0]  column;
      int          s, wl, hl, x0, y0, x1, y1, x2, y2, nx, col, row;
      bit          held_valid;
      rsp_type     held;
      cols = GLYPH_BITMAPS[font_slot(code)];
      s    = int'(line_scale);
      wl   = (fb_width > FB_LIMIT) ? int'(FB_LIMIT) : int'(fb_width);
      hl   = (fb_height > FB_LIMIT) ? int'(FB_LIMIT) : int'(fb_height);
      held = '0;
      held_valid = 1'b0;
      for (col = 0; col < 5; col++) begin
         column = cols[39 - 8*col -: 8];
         for (row = 0; row < 7; row++) begin
            if (column[row] && s != 0) begin
               x0 = int'(pen_x) + col * s;
               y0 = int'(line_y) + row * s;
               x1 = (x0 < 0) ? 0 : x0;
               y1 = (y0 < 0) ? 0 : y0;
               x2 = (x0 + s < wl) ? x0 + s : wl;
               y2 = (y0 + s < hl) ? y0 + s : hl;
               if (x2 > x1 && y2 > y1) begin
                  if (held_valid) begin
                     dot_rects.push_back(held);
                  end
                  held.rect_x      = 11'(x1);
                  held.rect_y      = 11'(y1);
                  held.rect_w      = 4'(x2 - x1);
                  held.rect_h      = 4'(y2 - y1);
                  held.rect_colour = line_colour;
                  held.last_rect   = 1'b0;
                  held_valid       = 1'b1;
               end
            end
         end
      end
      if (held_valid) begin
         held.last_rect = 1'b1;
         dot_rects.push_back(held);
      end
      nx = int'(pen_x) + 6 * s;
      if (nx > int'(CURSOR_MAX)) begin
         nx = int'(CURSOR_MAX);
      end
      pen_x = 16'(nx);
   endtask

   task automatic trace_request(input req_type item);
      int tw, x;
      case (item.opcode)
         OP_START_X, OP_START_CENTER: begin
            line_y      = item.pos_y;
            line_colour = item.ink_colour;
            line_scale  = item.pixel_scale;
            if (item.opcode == OP_START_X) begin
               pen_x = 16'($signed(item.pos_x));
            end else begin
               tw = int'(item.text_length) * 6 * int'(line_scale);
               x  = (int'(fb_width) - tw) / 2;
               pen_x = (x < 0) ? 16'sd0 : 16'(x);
            end
         end
         OP_CHAR: begin
            draw_char(item.char_code);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fb_width    = 12'd480;
         fb_height   = 12'd320;
         pen_x       = '0;
         line_y      = '0;
         line_colour = '0;
         line_scale  = '0;
         dot_rects.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == CSR_FB_WIDTH) begin
               fb_width = csr_pwdata[11:0];
            end else if (csr_paddr == CSR_FB_HEIGHT) begin
               fb_height = csr_pwdata[11:0];
            end
         end
         if (req_valid && req_ready) begin
            trace_request(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (dot_rects.size() == 0) begin
               report_mismatch("rectangle arrived with none predicted");
            end else begin
               want = dot_rects.pop_front();
               check_field("rect_x", 16'(rsp_payload.rect_x), 16'(want.rect_x));
               check_field("rect_y", 16'(rsp_payload.rect_y), 16'(want.rect_y));
               check_field("rect_w", 16'(rsp_payload.rect_w), 16'(want.rect_w));
               check_field("rect_h", 16'(rsp_payload.rect_h), 16'(want.rect_h));
               check_field("rect_colour", rsp_payload.rect_colour, want.rect_colour);
               check_field("last_rect", 16'(rsp_payload.last_rect), 16'(want.last_rect));
            end
            checked++;
         end
      end
      rects_in_flight <= dot_rects.size();
      rects_seen      <= checked;
      fail_count      <= mismatches;
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Top of the font text rectangle generator testbench: clock, reset, register writes,
// character stream stimulus and receiver stalls; the verdict comes from ftrg_rect_check.
// Depends on ftrg_pkg, ftrg_csr_map_pkg and the block itself.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ftrg_pkg::*;
   import ftrg_csr_map_pkg::*;

   localparam logic [1:0] OP_IGNORED    = 2'd3;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         SETTLE_CYCLES = 80;
   localparam int         PHASE_ITEMS   = 7;
   localparam int         WRAP_CHARS    = 26;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   req_type     req_payload = '0;
   logic        rsp_ready   = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          rects_in_flight;
   int          rects_seen;
   int          fail_count;

   int          items_sent    = 0;
   int          chars_sent    = 0;
   int          burst_left    = 0;
   int          sizes_used    = 1;
   int          cur_w         = 480;
   int          cur_h         = 320;
   bit          steady_sender = 1'b0;
   bit          hold_request  = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   font_text_rect_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ftrg_rect_check rect_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .rects_in_flight (rects_in_flight),
      .rects_seen      (rects_seen),
      .fail_count      (fail_count)
   );

   task automatic csr_write(input logic [2:0] addr, input logic [11:0] value);
      logic [31:0] data;
      data        = $urandom;
      data[11:0]  = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (rects_in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_req(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = steady_sender ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.opcode == OP_CHAR) begin
         chars_sent++;
      end
      if (r.opcode != OP_IGNORED) begin
         items_sent++;
      end
   endtask

   function automatic req_type make_req(input logic [1:0] op);
      logic [63:0] noise;
      req_type     r;
      noise    = {$urandom, $urandom};
      r        = noise[$bits(req_type)-1:0];
      r.opcode = op;
      return r;
   endfunction

   task automatic send_start(input logic [1:0] op, input int x, input int y, input int len,
                             input logic [15:0] colour, input logic [3:0] scale);
      req_type r;
      r             = make_req(op);
      r.pos_x       = 12'(x);
      r.pos_y       = 12'(y);
      r.text_length = 8'(len);
      r.ink_colour  = colour;
      r.pixel_scale = scale;
      send_req(r);
   endtask

   task automatic send_char(input logic [7:0] code);
      req_type r;
      r           = make_req(OP_CHAR);
      r.char_code = code;
      send_req(r);
   endtask

   task automatic send_noise();
      send_req(make_req(OP_IGNORED));
   endtask

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 5))
         0, 1:    return 8'($urandom_range("A", "Z"));
         2:       return 8'($urandom_range("a", "z"));
         3:       return 8'($urandom_range("0", "9"));
         4:       return $urandom_range(0, 1) ? "." : "-";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [3:0] pick_scale();
      case ($urandom_range(0, 9))
         0:       return 4'd0;
         1:       return 4'd15;
         2:       return 4'($urandom_range(5, 14));
         default: return 4'($urandom_range(1, 3));
      endcase
   endfunction

   function automatic int pick_coord(input int span);
      int v;
      if ($urandom_range(0, 3) == 0) begin
         v = $urandom_range(0, 4095) - 2048;
      end else begin
         v = $urandom_range(0, span + 60) - 40;
      end
      return (v > 2047) ? 2047 : v;
   endfunction

   task automatic random_line();
      int          len;
      logic [1:0]  op;
      if ($urandom_range(0, 3) != 0) begin
         op  = $urandom_range(0, 1) ? OP_START_CENTER : OP_START_X;
         len = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(1, 10);
         send_start(op, pick_coord(cur_w), pick_coord(cur_h), len, 16'($urandom),
                    pick_scale());
      end
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 19) == 0) begin
            send_noise();
         end
         send_char(pick_code());
      end
   endtask

   task automatic set_framebuffer(input int w, input int h);
      wait_idle();
      csr_write(CSR_FB_WIDTH, 12'(w));
      csr_write(CSR_FB_HEIGHT, 12'(h));
      cur_w = w;
      cur_h = h;
      sizes_used++;
   endtask

   initial begin
      int          phase;
      logic [15:0] pattern;
      phase   = 0;
      pattern = '1;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (phase == 0) begin
            case ($urandom_range(0, 2))
               0:       pattern = '1;
               1:       pattern = 16'($urandom) | 16'h0001;
               default: pattern = 16'($urandom & $urandom) | 16'h0001;
            endcase
         end
         rsp_ready <= pattern[phase % 16];
         phase = (phase + 1) % 48;
      end
   end

   initial begin
      int ph, w, h, phase_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_char("A");
      send_noise();
      send_start(OP_START_X, 0, 0, 0, 16'hFFFF, 4'd1);
      send_char("A");
      send_char("a");
      send_char("z");
      send_char("0");
      send_char("9");
      send_char(".");
      send_char("-");
      send_char(8'hFF);
      send_char(" ");
      send_start(OP_START_X, -2048, -2048, 255, 16'h0000, 4'd15);
      send_char("W");
      send_start(OP_START_X, -7, -5, 0, 16'hA5A5, 4'd3);
      send_char("M");
      send_start(OP_START_X, 470, 315, 0, 16'h5A5A, 4'd4);
      send_char("E");
      send_start(OP_START_X, 2047, 2047, 0, 16'h1234, 4'd15);
      send_char("8");
      send_start(OP_START_CENTER, 0, 100, 255, 16'h8001, 4'd15);
      send_char("B");
      send_start(OP_START_CENTER, 0, 300, 0, 16'h7FFE, 4'd1);
      send_char("Q");
      send_start(OP_START_X, 10, 10, 0, 16'hFFFF, 4'd0);
      send_char("H");

      // A long line far to the right walks the cursor past the 12-bit coordinate
      // range; a cursor that wrapped there would bring glyphs back on screen.
      steady_sender = 1'b1;
      send_start(OP_START_X, 2047, 100, 0, 16'hF00F, 4'd15);
      repeat (WRAP_CHARS) send_char("8");
      steady_sender = 1'b0;

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0:       begin w = 2048; h = 2048; end
            1:       begin w = 4095; h = 4095; end
            2:       begin w = 1;    h = 1;    end
            3:       begin w = 0;    h = 0;    end
            4:       begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
            5:       begin w = 0;    h = 320;  end
            default: begin w = 480;  h = 320;  end
         endcase
         set_framebuffer(w, h);
         steady_sender = (ph == 2 || ph == 6);
         if (ph == 1) begin
            hold_request = 1'b1;
            send_start(OP_START_X, 10, 10, 0, 16'hC3C3, 4'd2);
            send_char("8");
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_line();
      end

      wait_idle();
      $display("Sent %0d transactions (%0d characters) over %0d framebuffer sizes.",
               items_sent, chars_sent, sizes_used);
      $display("Compared %0d dot rectangles, with one long receiver hold-off.", rects_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/ftrg_pkg.sv
rtl/font_text_rect_generator.sv
rtl/ftrg_checker.sv
tb/ftrg_rect_check.sv
tb/tb.sv
